[src/swia_pkg.sv]
// -----------------------------------------------------------------------------
// swia_pkg
// Shared types and constants for the signed wide integer ALU.
// -----------------------------------------------------------------------------
package swia_pkg;

  localparam int DW        = 64;  // port data width
  localparam int HW        = 32;  // multiplier half width
  localparam int WIDTH_DEF = 64;  // default operating width

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4,
    OP_SHL = 3'd5,
    OP_SHR = 3'd6,
    OP_NOP = 3'd7
  } swia_op_t;

  // Payload carried down the pipeline
  typedef struct packed {
    swia_op_t        op;
    logic [DW-1:0]   res;   // finished result for simple ops
    logic [DW-1:0]   p0;    // aL*bL
    logic [HW-1:0]   p1;    // aH*bL, low half
    logic [HW-1:0]   p2;    // aL*bH, low half
    logic            neg;   // quotient sign
    logic            dz;    // zero divisor
    logic            gt;
    logic            eq;
    logic [DW-1:0]   n;     // dividend magnitude
    logic [DW-1:0]   d;     // divisor magnitude
    logic [DW-1:0]   q;     // partial quotient
    logic [DW-1:0]   r;     // partial remainder
  } swia_stage_t;

endpackage

[src/swia_req_if.sv]
// -----------------------------------------------------------------------------
// swia_req_if / swia_res_if
// Valid/ready channels for requests and results.
// -----------------------------------------------------------------------------
interface swia_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface swia_res_if;
  logic              valid;
  logic              ready;
  logic signed [63:0] result_value;
  logic              a_greater;
  logic              a_equal;
  logic              div_by_zero;
  modport source (output valid, result_value, a_greater, a_equal, div_by_zero,
                  input ready);
  modport sink   (input valid, result_value, a_greater, a_equal, div_by_zero,
                  output ready);
endinterface

[src/swia_front.sv]
// -----------------------------------------------------------------------------
// swia_front
// Decode stage: add/sub/compare/shift, divide setup, partial products.
// -----------------------------------------------------------------------------
module swia_front #(
  parameter int WIDTH = swia_pkg::WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [2:0]          in_op,
  input  logic [63:0]         in_a,
  input  logic [63:0]         in_b,
  output logic                vld_r,
  output swia_pkg::swia_stage_t stg_r
);
  import swia_pkg::*;

  localparam logic [DW-1:0] MASK = {DW{1'b1}} >> (DW - WIDTH);
  localparam logic [DW-1:0] WLIM = DW'(WIDTH);

  logic [DW-1:0] a, b, ma, mb;
  logic          na, nb;
  swia_stage_t   stg_nxt;
  swia_op_t      op;

  always_comb begin
    op = swia_op_t'(in_op);
    a  = in_a & MASK;
    b  = in_b & MASK;
    na = a[WIDTH-1];
    nb = b[WIDTH-1];
    ma = na ? ((~a + 1'b1) & MASK) : a;
    mb = nb ? ((~b + 1'b1) & MASK) : b;

    stg_nxt     = '0;
    stg_nxt.op  = op;
    stg_nxt.p0  = a[HW-1:0] * b[HW-1:0];
    stg_nxt.p1  = HW'(a[DW-1:HW] * b[HW-1:0]);
    stg_nxt.p2  = HW'(a[HW-1:0] * b[DW-1:HW]);
    stg_nxt.neg = na ^ nb;
    stg_nxt.n   = ma;
    stg_nxt.d   = mb;
    case (op)
      OP_ADD: stg_nxt.res = (a + b) & MASK;
      OP_SUB: stg_nxt.res = (a - b) & MASK;
      OP_DIV: stg_nxt.dz  = (mb == '0);
      OP_CMP: begin
        stg_nxt.eq = (a == b);
        stg_nxt.gt = (na != nb) ? nb : (a > b);
      end
      OP_SHL: stg_nxt.res = (b >= WLIM) ? '0 : ((a << b[5:0]) & MASK);
      OP_SHR: stg_nxt.res = (b >= WLIM) ? '0 : (a >> b[5:0]);
      default: stg_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

endmodule

[src/swia_div_stage.sv]
// -----------------------------------------------------------------------------
// swia_div_stage
// One restoring-division step: shift in a dividend bit, trial subtract.
// -----------------------------------------------------------------------------
module swia_div_stage #(
  parameter int BIT = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  swia_pkg::swia_stage_t in_stg,
  output logic                  vld_r,
  output swia_pkg::swia_stage_t stg_r
);
  import swia_pkg::*;

  logic [DW:0]  r_sh;
  logic         take;
  swia_stage_t  stg_nxt;

  always_comb begin
    r_sh    = {in_stg.r, in_stg.n[BIT]};
    take    = (r_sh >= {1'b0, in_stg.d});
    stg_nxt = in_stg;
    if (take) begin
      stg_nxt.r      = DW'(r_sh - {1'b0, in_stg.d});
      stg_nxt.q[BIT] = 1'b1;
    end else begin
      stg_nxt.r = r_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

endmodule

[src/swia_back.sv]
// -----------------------------------------------------------------------------
// swia_back
// Final stage: product sum, quotient sign, result select, output register.
// -----------------------------------------------------------------------------
module swia_back #(
  parameter int WIDTH = swia_pkg::WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  swia_pkg::swia_stage_t in_stg,
  output logic                  vld_r,
  output logic [63:0]           res_r,
  output logic                  gt_r,
  output logic                  eq_r,
  output logic                  dz_r
);
  import swia_pkg::*;

  localparam logic [DW-1:0] MASK = {DW{1'b1}} >> (DW - WIDTH);

  logic [DW-1:0] q, v, res_nxt;
  logic [HW-1:0] mid_sum;

  always_comb begin
    mid_sum = in_stg.p1 + in_stg.p2;
    q       = in_stg.dz ? MASK : (in_stg.q & MASK);
    case (in_stg.op)
      OP_MUL:  v = (in_stg.p0 + {mid_sum, {HW{1'b0}}}) & MASK;
      OP_DIV:  v = in_stg.neg ? ((~q + 1'b1) & MASK) : q;
      default: v = in_stg.res;
    endcase
    res_nxt = v[WIDTH-1] ? (v | ~MASK) : v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      gt_r  <= (in_stg.op == OP_CMP) && in_stg.gt;
      eq_r  <= (in_stg.op == OP_CMP) && in_stg.eq;
      dz_r  <= (in_stg.op == OP_DIV) && in_stg.dz;
    end
  end

endmodule

[src/signed_wide_integer_alu_unit.sv]
// -----------------------------------------------------------------------------
// signed_wide_integer_alu_unit
// Pipelined signed ALU: add, sub, mul (low half), div, compare, shifts.
// -----------------------------------------------------------------------------
// Pipeline: decode register, WIDTH divide-step registers, output register.
// Throughput: one request per cycle unless the result register is held; the divider resolves one bit per stage.
// Stall: the whole pipeline freezes while the result register is held.
// Reset: synchronous active-low rst_n clears all stage valid bits only.
module signed_wide_integer_alu_unit #(
  parameter int WIDTH = swia_pkg::WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  swia_req_if.sink   in_req,
  swia_res_if.source out_res
);
  import swia_pkg::*;

  // Global advance: move everything when the output slot is free or drains.
  logic adv;
  assign adv = !out_res.valid || out_res.ready;
  assign in_req.ready = adv;

  // Stage chain: index 0 is the decode register, index k after k div steps.
  logic        vld_c [0:WIDTH];
  swia_stage_t stg_c [0:WIDTH];

  swia_front #(.WIDTH(WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (in_req.valid),
    .in_op  (in_req.req_type),
    .in_a   (in_req.operand_a),
    .in_b   (in_req.operand_b),
    .vld_r  (vld_c[0]),
    .stg_r  (stg_c[0])
  );

  // Restoring divider, MSB first, one quotient bit per stage.
  for (genvar k = 0; k < WIDTH; k++) begin : g_div
    swia_div_stage #(.BIT(WIDTH - 1 - k)) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .in_vld (vld_c[k]),
      .in_stg (stg_c[k]),
      .vld_r  (vld_c[k+1]),
      .stg_r  (stg_c[k+1])
    );
  end

  logic [63:0] res_o;

  swia_back #(.WIDTH(WIDTH)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (vld_c[WIDTH]),
    .in_stg (stg_c[WIDTH]),
    .vld_r  (out_res.valid),
    .res_r  (res_o),
    .gt_r   (out_res.a_greater),
    .eq_r   (out_res.a_equal),
    .dz_r   (out_res.div_by_zero)
  );

  assign out_res.result_value = res_o;

  // Divide and compare flags never appear together.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.div_by_zero |-> !out_res.a_greater && !out_res.a_equal)
    else $error("divide flag with compare flag");

  // Compare requests give a zero result.
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && (out_res.a_greater || out_res.a_equal) |-> out_res.result_value == 0)
    else $error("compare result not zero");

  // A stalled result keeps its value and its divide-by-zero flag.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=> $stable(out_res.div_by_zero) && $stable(res_o))
    else $error("stalled result changed");

endmodule

[dv/tb_signed_wide_integer_alu_unit.sv]
// -----------------------------------------------------------------------------
// tb_signed_wide_integer_alu_unit
// Checks the signed ALU against its own predictor: a directed table of
// requests, then about 1400 random ones, with random gaps and stalls on both
// channels, one long result back-pressure window and one drain pause.
// -----------------------------------------------------------------------------
module tb_signed_wide_integer_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import swia_pkg::*;

  localparam int W         = WIDTH_DEF;
  localparam int N_RANDOM  = 1400;
  localparam int LATENCY   = W + 2;
  localparam int STALL_MAX = 2000;  // cycles with no transfer before giving up

  typedef struct packed {
    logic [63:0] value;
    logic        gt;
    logic        eq;
    logic        dz;
  } alu_result_t;

  // One directed row; chk_exp set where the answer is typed in by hand.
  typedef struct {
    swia_op_t    op;
    logic [63:0] a;
    logic [63:0] b;
    bit          chk_exp;
    alu_result_t exp;
  } stim_row_t;

  logic clk;
  logic rst_n;

  swia_req_if req_ch ();
  swia_res_if res_ch ();

  signed_wide_integer_alu_unit #(.WIDTH(W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch.sink),
    .out_res(res_ch.source)
  );

  alu_result_t pending_results[$];
  int          errors;
  int          idle_cycles;
  bit          sink_hold;      // long back-pressure window
  bit          sink_quiet;     // no random stalls
  bit          source_quiet;   // no random gaps
  bit          stim_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] wmask();
    return {64{1'b1}} >> (64 - W);
  endfunction

  function automatic logic [63:0] sign_ext(logic [63:0] v);
    logic [63:0] m;
    m = wmask();
    v = v & m;
    if (v[W-1]) begin
      v = v | ~m;
    end
    return v;
  endfunction

  function automatic logic [63:0] neg_w(logic [63:0] v);
    return (~v + 64'd1) & wmask();
  endfunction

  // Bit-serial restoring divide of two unsigned magnitudes; d is nonzero.
  function automatic logic [63:0] restore_divide(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    logic        top;
    q = '0;
    r = '0;
    for (int i = W - 1; i >= 0; i--) begin
      top = r[63];
      r   = {r[62:0], n[i]};
      if (top || r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q & wmask();
  endfunction

  function automatic alu_result_t alu_predict(swia_op_t op, logic [63:0] ain,
                                              logic [63:0] bin);
    alu_result_t res;
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic [63:0] v;
    logic        na;
    logic        nb;
    m   = wmask();
    a   = ain & m;
    b   = bin & m;
    na  = a[W-1];
    nb  = b[W-1];
    v   = '0;
    res = '0;
    case (op)
      OP_ADD: v = (a + b) & m;
      OP_SUB: v = (a - b) & m;
      OP_MUL: v = (a * b) & m;
      OP_DIV: begin
        ma = na ? neg_w(a) : a;
        mb = nb ? neg_w(b) : b;
        if (mb == '0) begin
          res.dz = 1'b1;
          q      = m;
        end else begin
          q = restore_divide(ma, mb);
        end
        v = (na != nb) ? neg_w(q) : q;
      end
      OP_CMP: begin
        res.eq = (a == b);
        res.gt = (na != nb) ? nb : (a > b);
      end
      OP_SHL: v = (b >= W) ? '0 : ((a << b) & m);
      OP_SHR: v = (b >= W) ? '0 : ((a >> b) & m);
      default: v = '0;
    endcase
    res.value = sign_ext(v);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  task automatic send_request(swia_op_t op, logic [63:0] a, logic [63:0] b);
    while (!source_quiet && $urandom_range(99) < 15) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= op;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    pending_results.insert(pending_results.size(), alu_predict(op, a, b));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = {{63{1'b0}}, 1'b0};
      1: v = sign_ext(64'd1 << (W - 1));       // most negative
      2: v = sign_ext(wmask() >> 1);           // most positive
      3: v = {64{1'b1}};                       // minus one
      4: v = sign_ext({$urandom} & 64'hff);    // small magnitude
      5: v = sign_ext(-(64'($urandom_range(20))));
      default: ;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t   rows[$];
    logic [63:0] min_v;
    logic [63:0] max_v;
    logic [63:0] a;
    logic [63:0] b;
    swia_op_t    op;

    min_v = sign_ext(64'd1 << (W - 1));
    max_v = sign_ext(wmask() >> 1);

    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= OP_NOP;
    req_ch.operand_a <= '0;
    req_ch.operand_b <= '0;
    sink_hold        = 1'b0;
    sink_quiet       = 1'b0;
    source_quiet     = 1'b0;
    stim_done        = 1'b0;
    rst_n            <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, each op, flags outside their op, the
    // zero divisor, min / -1, large shift amounts and the unused code.
    rows = '{
      '{OP_ADD, max_v, 64'd1,      1'b1, '{min_v, 1'b0, 1'b0, 1'b0}},
      '{OP_SUB, min_v, 64'd1,      1'b1, '{max_v, 1'b0, 1'b0, 1'b0}},
      '{OP_MUL, min_v, {64{1'b1}}, 1'b1, '{min_v, 1'b0, 1'b0, 1'b0}},
      '{OP_MUL, max_v, max_v,      1'b0, '0},
      '{OP_DIV, min_v, {64{1'b1}}, 1'b1, '{min_v, 1'b0, 1'b0, 1'b0}},
      '{OP_DIV, 64'd7, 64'd0,      1'b1, '{{64{1'b1}}, 1'b0, 1'b0, 1'b1}},
      '{OP_DIV, {64{1'b1}}, 64'd0, 1'b1, '{64'd1, 1'b0, 1'b0, 1'b1}},
      '{OP_DIV, 64'd0, 64'd0,      1'b1, '{{64{1'b1}}, 1'b0, 1'b0, 1'b1}},
      '{OP_DIV, -64'sd7, 64'd2,    1'b1, '{-64'sd3, 1'b0, 1'b0, 1'b0}},
      '{OP_DIV, max_v, min_v,      1'b0, '0},
      '{OP_CMP, max_v, min_v,      1'b1, '{64'd0, 1'b1, 1'b0, 1'b0}},
      '{OP_CMP, min_v, max_v,      1'b1, '{64'd0, 1'b0, 1'b0, 1'b0}},
      '{OP_CMP, min_v, min_v,      1'b1, '{64'd0, 1'b0, 1'b1, 1'b0}},
      '{OP_CMP, -64'sd2, -64'sd3,  1'b1, '{64'd0, 1'b1, 1'b0, 1'b0}},
      '{OP_SHL, 64'd1, 64'(W - 1), 1'b1, '{min_v, 1'b0, 1'b0, 1'b0}},
      '{OP_SHL, {64{1'b1}}, 64'(W),1'b1, '{64'd0, 1'b0, 1'b0, 1'b0}},
      '{OP_SHR, {64{1'b1}}, 64'(W - 1), 1'b1, '{64'd1, 1'b0, 1'b0, 1'b0}},
      '{OP_SHR, min_v, {64{1'b1}}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b0}},
      '{OP_SHR, max_v, 64'd0,      1'b0, '0},
      '{OP_NOP, max_v, max_v,      1'b1, '{64'd0, 1'b0, 1'b0, 1'b0}},
      '{OP_NOP, {64{1'b1}}, {64{1'b1}}, 1'b0, '0}
    };
    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].a, rows[i].b);
      // Hand-typed rows replace the predicted entry just queued.
      if (rows[i].chk_exp) begin
        void'(pending_results.pop_back());
        pending_results.insert(pending_results.size(), rows[i].exp);
      end
    end

    // Sender pauses until everything is back.
    wait_drained();

    for (int n = 0; n < N_RANDOM; n++) begin
      source_quiet = (n >= 300 && n < 500);
      sink_quiet   = (n >= 300 && n < 500);
      // Long result stall while a request waits: the whole pipeline freezes.
      if (n == 700) begin
        sink_hold = 1'b1;
      end
      op = swia_op_t'($urandom_range(7));
      a  = rand_operand();
      b  = rand_operand();
      if ((op == OP_SHL || op == OP_SHR) && $urandom_range(3) != 0) begin
        b = 64'($urandom_range(W + 2));
      end
      send_request(op, a, b);
    end
    req_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Hold-off window counted in its own process.
  initial begin
    wait (sink_hold);
    repeat (3 * LATENCY) @(posedge clk);
    sink_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= !sink_hold && (sink_quiet || $urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    alu_result_t exp_res;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_value %h", res_ch.result_value);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res_ch.result_value !== exp_res.value) begin
          $error("result_value exp %h got %h", exp_res.value, res_ch.result_value);
          errors++;
        end
        if (res_ch.a_greater !== exp_res.gt) begin
          $error("a_greater exp %b got %b", exp_res.gt, res_ch.a_greater);
          errors++;
        end
        if (res_ch.a_equal !== exp_res.eq) begin
          $error("a_equal exp %b got %b", exp_res.eq, res_ch.a_equal);
          errors++;
        end
        if (res_ch.div_by_zero !== exp_res.dz) begin
          $error("div_by_zero exp %b got %b", exp_res.dz, res_ch.div_by_zero);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors      = 0;
    idle_cycles = 0;
    fork
      begin
        wait (stim_done && pending_results.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
      end
      begin
        wait (idle_cycles >= STALL_MAX);
        errors++;
        $display("watchdog: no transfer for %0d cycles", STALL_MAX);
      end
    join_any
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
